[rtl/tap_pkg.sv]
// ----------------------------------------------------------------------------
// tap_pkg
// shared types and constants for the three-axis fixed-point pid block
// ----------------------------------------------------------------------------
package tap_pkg;

    localparam int WORD_BITS = 16;
    localparam int FRAC_BITS = 7;
    localparam int AXES      = 3;
    localparam int GAIN_BITS = 3 * WORD_BITS;
    localparam int DIVD_BITS = WORD_BITS + 1 + FRAC_BITS;
    localparam int QUO_BITS  = DIVD_BITS + 1;
    localparam int MULA_BITS = 2 * WORD_BITS;
    localparam int PROD_BITS = MULA_BITS + WORD_BITS;
    localparam int CNT_BITS  = $clog2(DIVD_BITS + 1);
    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_ROLL_GAINS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_PITCH_GAINS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_YAW_GAINS   = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_TIME_STEP   = 2'd3;

    localparam logic [1:0] AX_ROLL  = 2'd0;
    localparam logic [1:0] AX_PITCH = 2'd1;
    localparam logic [1:0] AX_YAW   = 2'd2;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] roll_target;
        logic signed [WORD_BITS-1:0] roll_measured;
        logic signed [WORD_BITS-1:0] pitch_target;
        logic signed [WORD_BITS-1:0] pitch_measured;
        logic signed [WORD_BITS-1:0] yaw_target;
        logic signed [WORD_BITS-1:0] yaw_measured;
    } in_t;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] roll_drive;
        logic signed [WORD_BITS-1:0] pitch_drive;
        logic signed [WORD_BITS-1:0] yaw_drive;
    } out_t;

    typedef struct packed {
        logic                        start;
        logic signed [DIVD_BITS-1:0] dividend;
        logic signed [WORD_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                       done;
        logic signed [QUO_BITS-1:0] quotient;
    } div_rsp_t;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_ERR  = 10'b0000000010,
        S_MP   = 10'b0000000100,
        S_MI1  = 10'b0000001000,
        S_MI2  = 10'b0000010000,
        S_ISUM = 10'b0000100000,
        S_DIV  = 10'b0001000000,
        S_MD   = 10'b0010000000,
        S_DSH  = 10'b0100000000,
        S_SUM  = 10'b1000000000
    } state_t;

endpackage

[rtl/tap_div.sv]
// ----------------------------------------------------------------------------
// tap_div
// signed restoring divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module tap_div
    import tap_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [WORD_BITS-1:0] rem_reg, rem_next;
    logic [DIVD_BITS-1:0] quo_reg, quo_next;
    logic [WORD_BITS-1:0] dvs_reg, dvs_next;
    logic                 neg_reg, neg_next;
    logic [WORD_BITS:0]   rem_sh;
    logic [WORD_BITS:0]   rem_sub;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg, quo_reg[DIVD_BITS-1]};
        rem_sub   = rem_sh - {1'b0, dvs_reg};
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVD_BITS);
            rem_next  = '0;
            quo_next  = req.dividend[DIVD_BITS-1] ? DIVD_BITS'(-req.dividend)
                                                  : DIVD_BITS'(req.dividend);
            dvs_next  = req.divisor[WORD_BITS-1] ? WORD_BITS'(-req.divisor)
                                                 : WORD_BITS'(req.divisor);
            neg_next  = req.dividend[DIVD_BITS-1] ^ req.divisor[WORD_BITS-1];
        end
        else if (busy_reg)
        begin
            if (!rem_sub[WORD_BITS])
            begin
                rem_next = rem_sub[WORD_BITS-1:0];
                quo_next = {quo_reg[DIVD_BITS-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[WORD_BITS-1:0];
                quo_next = {quo_reg[DIVD_BITS-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
        neg_reg <= neg_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});

`ifndef SYNTHESIS
    a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg)
        else $error("divider done while busy");
    a_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> cnt_reg != '0)
        else $error("divider busy with zero count");
`endif

endmodule

[rtl/three_axis_pid_fixed.sv]
// per request: the three axes run in turn; a zero time step skips the divide and the d term
// per axis: error, then p and i, then the divide, then the d term and the sum
// one request at a time: new requests are stalled until the block returns to idle
// a waiting result holds the next request at its last axis until the result is taken
// reset: gains, integral and last error clear, time step returns to 1.0
// ----------------------------------------------------------------------------
// three_axis_pid_fixed
// three-axis pid controller in signed q9.7, one shared multiplier and divider
// ----------------------------------------------------------------------------
module three_axis_pid_fixed
    import tap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  in_t                     in_data,
    output logic                    out_valid,
    input  logic                    out_stall,
    output out_t                    out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]    cfg_data
);

    state_t                      state_reg, state_next;
    logic [1:0]                  ax_reg, ax_next;
    in_t                         in_reg, in_next;
    logic [GAIN_BITS-1:0]        gains_reg [AXES];
    logic signed [WORD_BITS-1:0] dt_reg;
    logic signed [WORD_BITS-1:0] integ_reg [AXES];
    logic signed [WORD_BITS-1:0] last_reg [AXES];
    logic signed [WORD_BITS-1:0] drv_reg [AXES];
    logic signed [WORD_BITS-1:0] e_reg, e_next;
    logic signed [WORD_BITS:0]   diff_reg, diff_next;
    logic signed [WORD_BITS-1:0] p_reg, p_next;
    logic signed [WORD_BITS-1:0] i_reg, i_next;
    logic signed [WORD_BITS-1:0] d_reg, d_next;
    logic signed [QUO_BITS-1:0]  q_reg, q_next;
    logic signed [PROD_BITS-1:0] prod_reg, prod_next;
    logic                        out_valid_reg, out_valid_next;
    out_t                        out_reg, out_next;
    logic                        commit;
    logic signed [MULA_BITS-1:0] mul_a;
    logic signed [WORD_BITS-1:0] mul_b;
    logic signed [WORD_BITS-1:0] tgt, mea;
    logic [GAIN_BITS-1:0]        g;
    div_req_t                    dreq;
    div_rsp_t                    drsp;

    tap_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    always_comb
    begin
        case (ax_reg)
            AX_ROLL:
            begin
                tgt = in_reg.roll_target;
                mea = in_reg.roll_measured;
            end
            AX_PITCH:
            begin
                tgt = in_reg.pitch_target;
                mea = in_reg.pitch_measured;
            end
            default:
            begin
                tgt = in_reg.yaw_target;
                mea = in_reg.yaw_measured;
            end
        endcase
    end

    assign g = gains_reg[ax_reg];

    // shared multiplier operand select
    always_comb
    begin
        mul_a = MULA_BITS'(e_reg);
        mul_b = g[GAIN_BITS-1 -: WORD_BITS];
        case (state_reg)
            S_MI1:
            begin
                mul_a = MULA_BITS'(e_reg);
                mul_b = g[2*WORD_BITS-1 -: WORD_BITS];
            end
            S_MI2:
            begin
                mul_a = prod_reg[MULA_BITS-1:0];
                mul_b = dt_reg;
            end
            S_MD:
            begin
                mul_a = MULA_BITS'(q_reg);
                mul_b = g[WORD_BITS-1:0];
            end
            default:
            begin
                mul_a = MULA_BITS'(e_reg);
                mul_b = g[GAIN_BITS-1 -: WORD_BITS];
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        ax_next        = ax_reg;
        in_next        = in_reg;
        e_next         = e_reg;
        diff_next      = diff_reg;
        p_next         = p_reg;
        i_next         = i_reg;
        d_next         = d_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        commit         = 1'b0;
        out_next       = out_reg;
        out_valid_next = out_valid_reg && out_stall;
        dreq.start     = 1'b0;
        dreq.dividend  = {diff_reg, {FRAC_BITS{1'b0}}};
        dreq.divisor   = dt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    in_next    = in_data;
                    ax_next    = AX_ROLL;
                    state_next = S_ERR;
                end
            end
            S_ERR:
            begin
                e_next     = WORD_BITS'(tgt - mea);
                diff_next  = (WORD_BITS+1)'(e_next) - (WORD_BITS+1)'(last_reg[ax_reg]);
                state_next = S_MP;
            end
            S_MP:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_MI1;
            end
            S_MI1:
            begin
                p_next     = prod_reg[FRAC_BITS +: WORD_BITS];
                prod_next  = mul_a * mul_b;
                state_next = S_MI2;
            end
            S_MI2:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_ISUM;
            end
            S_ISUM:
            begin
                i_next = integ_reg[ax_reg] + prod_reg[2*FRAC_BITS +: WORD_BITS];
                if (dt_reg == '0)
                begin
                    d_next     = '0;
                    state_next = S_SUM;
                end
                else
                begin
                    dreq.start = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (drsp.done)
                begin
                    q_next     = drsp.quotient;
                    state_next = S_MD;
                end
            end
            S_MD:
            begin
                prod_next  = mul_a * mul_b;
                state_next = S_DSH;
            end
            S_DSH:
            begin
                d_next     = prod_reg[FRAC_BITS +: WORD_BITS];
                state_next = S_SUM;
            end
            S_SUM:
            begin
                if (ax_reg != AX_YAW)
                begin
                    commit     = 1'b1;
                    ax_next    = ax_reg + 1'b1;
                    state_next = S_ERR;
                end
                else if (!out_valid_reg || !out_stall)
                begin
                    commit              = 1'b1;
                    out_next.roll_drive  = drv_reg[AX_ROLL];
                    out_next.pitch_drive = drv_reg[AX_PITCH];
                    out_next.yaw_drive   = p_reg + i_reg + d_reg;
                    out_valid_next      = 1'b1;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ax_reg        <= AX_ROLL;
            out_valid_reg <= 1'b0;
            dt_reg        <= WORD_BITS'(1 << FRAC_BITS);
            for (int k = 0; k < AXES; k++)
            begin
                gains_reg[k] <= '0;
                integ_reg[k] <= '0;
                last_reg[k]  <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            ax_reg        <= ax_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_ROLL_GAINS:  gains_reg[AX_ROLL]  <= cfg_data;
                    REG_PITCH_GAINS: gains_reg[AX_PITCH] <= cfg_data;
                    REG_YAW_GAINS:   gains_reg[AX_YAW]   <= cfg_data;
                    REG_TIME_STEP:   dt_reg <= cfg_data[WORD_BITS-1:0];
                    default:         dt_reg <= dt_reg;
                endcase
            end
            if (commit)
            begin
                integ_reg[ax_reg] <= i_reg;
                last_reg[ax_reg]  <= e_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        in_reg   <= in_next;
        e_reg    <= e_next;
        diff_reg <= diff_next;
        p_reg    <= p_next;
        i_reg    <= i_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
        if (commit)
        begin
            drv_reg[ax_reg] <= p_reg + i_reg + d_reg;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

`ifndef SYNTHESIS
    a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        drsp.done |-> state_reg == S_DIV)
        else $error("divider finished outside divide wait");
    a_div_needs_dt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> dt_reg != '0)
        else $error("divide with zero time step");
    a_axis_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> ax_reg != 2'd3)
        else $error("axis index out of range");
    a_result_on_last_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !$past(out_valid_reg)) |-> $past(ax_reg) == AX_YAW)
        else $error("result raised before last axis");
`endif

endmodule

[dv/three_axis_pid_fixed_checker.sv]
// ----------------------------------------------------------------------------
// three_axis_pid_fixed_checker
// watches the request and result channels and the register port, predicts the
// pid drives per axis and compares each accepted result with the oldest one
// ----------------------------------------------------------------------------
module three_axis_pid_fixed_checker
    import tap_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    input  logic                    in_stall,
    input  in_t                     in_data,
    input  logic                    out_valid,
    input  logic                    out_stall,
    input  out_t                    out_data,
    input  logic                    cfg_we,
    input  logic [CFG_IDX_BITS-1:0] cfg_index,
    input  logic [GAIN_BITS-1:0]    cfg_data,
    output int                      errors,
    output int                      pending
);

    logic [GAIN_BITS-1:0]        gain_reg [AXES];
    logic signed [WORD_BITS-1:0] dt_reg;
    logic signed [WORD_BITS-1:0] integ [AXES];
    logic signed [WORD_BITS-1:0] prev_err [AXES];
    out_t                        drive_q [$];

    assign pending = drive_q.size();

    function automatic logic signed [WORD_BITS-1:0] pid_axis(input int ax,
        input logic signed [WORD_BITS-1:0] tgt, input logic signed [WORD_BITS-1:0] mea);
        logic signed [WORD_BITS-1:0] e, kp, ki, kd, p, i, d;
        longint pe, ie, q, diff;
        e  = tgt - mea;
        kp = gain_reg[ax][3*WORD_BITS-1:2*WORD_BITS];
        ki = gain_reg[ax][2*WORD_BITS-1:WORD_BITS];
        kd = gain_reg[ax][WORD_BITS-1:0];
        pe = longint'(kp) * longint'(e);
        p  = WORD_BITS'(pe >>> FRAC_BITS);
        ie = longint'(ki) * longint'(e) * longint'(dt_reg);
        i  = integ[ax] + WORD_BITS'(ie >>> (2 * FRAC_BITS));
        d  = '0;
        if (dt_reg != 0)
        begin
            diff = longint'(e) - longint'(prev_err[ax]);
            q = (diff * (64'sd1 <<< FRAC_BITS)) / longint'(dt_reg);
            d = WORD_BITS'((longint'(kd) * q) >>> FRAC_BITS);
        end
        integ[ax]    = i;
        prev_err[ax] = e;
        return p + i + d;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0d expected %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        out_t drv;
        if (!rst_n)
        begin
            for (int k = 0; k < AXES; k++)
            begin
                gain_reg[k] = '0;
                integ[k]    = '0;
                prev_err[k] = '0;
            end
            dt_reg = 16'sd128;
            errors = 0;
            drive_q.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (drive_q.size() == 0)
                    report_mismatch("unexpected result", 0, 0);
                else
                begin
                    want = drive_q.pop_front();
                    if (out_data.roll_drive !== want.roll_drive)
                        report_mismatch("roll_drive", out_data.roll_drive, want.roll_drive);
                    if (out_data.pitch_drive !== want.pitch_drive)
                        report_mismatch("pitch_drive", out_data.pitch_drive,
                                        want.pitch_drive);
                    if (out_data.yaw_drive !== want.yaw_drive)
                        report_mismatch("yaw_drive", out_data.yaw_drive, want.yaw_drive);
                end
            end
            if (in_valid && !in_stall)
            begin
                drv.roll_drive  = pid_axis(0, in_data.roll_target, in_data.roll_measured);
                drv.pitch_drive = pid_axis(1, in_data.pitch_target, in_data.pitch_measured);
                drv.yaw_drive   = pid_axis(2, in_data.yaw_target, in_data.yaw_measured);
                drive_q.push_back(drv);
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_TIME_STEP)
                    dt_reg = cfg_data[WORD_BITS-1:0];
                else
                    gain_reg[cfg_index] = cfg_data;
            end
        end
    end

endmodule

[dv/three_axis_pid_fixed_tb.sv]
// ----------------------------------------------------------------------------
// three_axis_pid_fixed_tb
// drives directed and random requests through several gain and time step
// settings with random gaps and stalls plus one long output hold-off
// ----------------------------------------------------------------------------
module three_axis_pid_fixed_tb;
    import tap_pkg::*;

    localparam int WATCHDOG = 20000;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    in_t                     in_data = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    out_t                    out_data;
    logic                    cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_index = '0;
    logic [GAIN_BITS-1:0]    cfg_data = '0;
    int                      errors;
    int                      pending;
    int                      idle_cycles = 0;
    bit                      hold_off = 1'b0;
    bit                      random_stall = 1'b1;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    three_axis_pid_fixed u_top (.*);

    three_axis_pid_fixed_checker u_check (.*);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("three_axis_pid_fixed_tb: errors");
            $finish;
        end
    end

    // result side: random stall per result, long hold-off on request
    initial
    begin
        int n;
        forever
        begin
            @(posedge clk);
            if (hold_off)
            begin
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
                out_stall <= 1'b0;
            end
            else if (out_valid && !out_stall)
            begin
                n = random_stall ? $urandom_range(0, 18) : 0;
                if ($urandom_range(0, 3) == 0)
                    n = 0;
                if (n > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (n - 1) @(posedge clk);
                    @(posedge clk);
                    out_stall <= 1'b0;
                end
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [GAIN_BITS-1:0] v);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_request(input in_t req, input bit gaps);
        int n;
        n = gaps ? $urandom_range(0, 18) : 0;
        if ($urandom_range(0, 2) == 0)
            n = 0;
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= req;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    function automatic logic signed [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            3: return $urandom_range(0, 1) ? 16'sh0080 : -16'sh0080;
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [GAIN_BITS-1:0] pick_gains();
        return {pick_word(), pick_word(), pick_word()};
    endfunction

    function automatic in_t random_request();
        in_t r;
        r = {pick_word(), pick_word(), pick_word(), pick_word(), pick_word(), pick_word()};
        if ($urandom_range(0, 3) == 0)
            r = {$urandom, $urandom, $urandom};
        return r;
    endfunction

    initial
    begin
        logic signed [WORD_BITS-1:0] dts [6];
        dts = '{16'sd128, 16'sd0, -16'sd1, 16'sh7fff, 16'sh8000, 16'sd1};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default gains of zero, then full-scale gains and field extremes
        send_request('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sd0, 16'sd0}, 1'b0);
        settle();
        write_reg(REG_ROLL_GAINS, {16'sh7fff, 16'sh7fff, 16'sh7fff});
        write_reg(REG_PITCH_GAINS, {16'sh8000, 16'sh8000, 16'sh8000});
        write_reg(REG_YAW_GAINS, {16'sh0080, 16'shff80, 16'sh0001});
        send_request('{16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff, 16'shffff, 16'sh0001}, 1'b0);
        send_request('{16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff}, 1'b0);
        send_request('{16'sh0000, 16'sh0000, 16'shffff, 16'shffff, 16'sh5555, 16'shaaaa}, 1'b0);
        settle();
        for (int k = 1; k < 6; k++)
        begin
            write_reg(REG_TIME_STEP, {32'd0, dts[k]});
            for (int j = 0; j < 3; j++)
                send_request(random_request(), 1'b1);
            settle();
        end

        // long result hold-off while requests keep coming
        write_reg(REG_TIME_STEP, 48'd128);
        hold_off = 1'b1;
        for (int j = 0; j < 10; j++)
            send_request(random_request(), 1'b0);
        settle();

        // random phases, each with fresh registers
        for (int ph = 0; ph < 16; ph++)
        begin
            write_reg(REG_ROLL_GAINS, pick_gains());
            write_reg(REG_PITCH_GAINS, pick_gains());
            write_reg(REG_YAW_GAINS, pick_gains());
            write_reg(REG_TIME_STEP, (ph % 3 == 0) ? {32'd0, dts[ph % 6]}
                                                   : {32'd0, pick_word()});
            random_stall = (ph % 4 != 3);
            for (int j = 0; j < 48; j++)
                send_request(random_request(), random_stall);
            settle();
        end

        if (errors == 0)
            $display("three_axis_pid_fixed_tb: clean");
        else
            $display("three_axis_pid_fixed_tb: errors");
        $finish;
    end

endmodule

[sim.f]
rtl/tap_pkg.sv
rtl/tap_div.sv
rtl/three_axis_pid_fixed.sv
dv/three_axis_pid_fixed_checker.sv
dv/three_axis_pid_fixed_tb.sv
